// File: rtl/ljpf_pkg.sv
// ----------------------------------------------------------------------------
// ljpf_pkg
// Shared types, constants and helpers for the Lennard-Jones pair force core.
// ----------------------------------------------------------------------------
package ljpf_pkg;

    localparam int FORCE_WIDTH    = 48;
    localparam int ATOM_COUNT_DEF = 1024;

    localparam int LIMB_W    = 32;
    localparam int MAC_A_W   = 224;   // seven limbs of multiplicand
    localparam int MAC_B_W   = 64;    // two limbs of multiplier
    localparam int MAC_P_W   = 256;   // product accumulator
    localparam int DIV_HI_W  = 90;
    localparam int DIV_W     = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 2'd1;

    localparam logic [19:0] SIGMA_RST   = 20'd317000;
    localparam logic [23:0] EPSILON_RST = 24'd657000;

    // 24 * 1e-27 J / 1e-15 m expressed in 1e-21 N units, times 1e9 scaling.
    localparam logic [MAC_B_W-1:0] K_SCALE = 64'd24000000000;

    localparam logic signed [FORCE_WIDTH-1:0] F_MAX = {1'b0, {(FORCE_WIDTH-1){1'b1}}};
    localparam logic signed [FORCE_WIDTH-1:0] F_MIN = {1'b1, {(FORCE_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic               func;
        logic [9:0]         first_index;
        logic [9:0]         second_index;
        logic signed [31:0] first_px;
        logic signed [31:0] first_py;
        logic signed [31:0] first_pz;
        logic signed [31:0] second_px;
        logic signed [31:0] second_py;
        logic signed [31:0] second_pz;
        logic               bank;
    } ljpf_in_t;

    typedef struct packed {
        logic signed [FORCE_WIDTH-1:0] pair_fx;
        logic signed [FORCE_WIDTH-1:0] pair_fy;
        logic signed [FORCE_WIDTH-1:0] pair_fz;
        logic signed [FORCE_WIDTH-1:0] sum_first_x;
        logic signed [FORCE_WIDTH-1:0] sum_first_y;
        logic signed [FORCE_WIDTH-1:0] sum_first_z;
        logic signed [FORCE_WIDTH-1:0] sum_second_x;
        logic signed [FORCE_WIDTH-1:0] sum_second_y;
        logic signed [FORCE_WIDTH-1:0] sum_second_z;
        logic                          zero_distance;
    } ljpf_out_t;

    typedef struct packed {
        logic signed [FORCE_WIDTH-1:0] x;
        logic signed [FORCE_WIDTH-1:0] y;
        logic signed [FORCE_WIDTH-1:0] z;
    } sum3_t;

    typedef struct packed {
        logic               done;
        logic [MAC_P_W-1:0] prod;
    } mac_res_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [DIV_W-1:0] quot;
    } div_res_t;

    // Add with clamping to the signed force range.
    function automatic logic signed [FORCE_WIDTH-1:0] sat_add(
        input logic signed [FORCE_WIDTH-1:0] a,
        input logic signed [FORCE_WIDTH-1:0] b
    );
        logic signed [FORCE_WIDTH:0] s;
        s = {a[FORCE_WIDTH-1], a} + {b[FORCE_WIDTH-1], b};
        if (s[FORCE_WIDTH] != s[FORCE_WIDTH-1]) begin
            return s[FORCE_WIDTH] ? F_MIN : F_MAX;
        end
        return s[FORCE_WIDTH-1:0];
    endfunction

endpackage

// File: rtl/lennard_jones_pair_force_accumulate_core.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_accumulate_core
// 12-6 Lennard-Jones pair force in fixed point, accumulated into two banks.
// ----------------------------------------------------------------------------
// A clear item or a far pair skips the arithmetic; a full pair force with an
// offset on all three axes is dominated by the 64-step divider that runs once
// for (sigma/r)^2 and once per nonzero axis, and by the 32x32 limb multiplier.
// One item is in work at a time; the result register lets the next item start
// while the previous result waits. After reset the sums are zeroed by a sweep
// over all 2*2^clog2(ATOM_COUNT) entries (2048 by default).
module lennard_jones_pair_force_accumulate_core import ljpf_pkg::*; #(
    parameter int ATOM_COUNT = ATOM_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ljpf_in_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output ljpf_out_t             m_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = $clog2(ATOM_COUNT);

    // The atom index is reduced modulo ATOM_COUNT with a reciprocal multiply
    // and one correcting subtract; the estimate is never more than one low.
    localparam logic [20:0] RECIP = 21'((1 << 20) / ATOM_COUNT);
    localparam logic [16:0] AC_V  = 17'(ATOM_COUNT);

    // Sequencer states.
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PREP   = 4'd1;
    localparam logic [3:0] S_ADDR   = 4'd2;
    localparam logic [3:0] S_MSTART = 4'd3;
    localparam logic [3:0] S_MWAIT  = 4'd4;
    localparam logic [3:0] S_DSTART = 4'd5;
    localparam logic [3:0] S_DWAIT  = 4'd6;
    localparam logic [3:0] S_COMP   = 4'd7;
    localparam logic [3:0] S_HUGE   = 4'd8;
    localparam logic [3:0] S_RD1    = 4'd9;
    localparam logic [3:0] S_WR1    = 4'd10;
    localparam logic [3:0] S_RD2    = 4'd11;
    localparam logic [3:0] S_WR2    = 4'd12;
    localparam logic [3:0] S_OUT    = 4'd13;

    // Multiply steps on the shared unit.
    localparam logic [3:0] ST_RX  = 4'd0;   // dx^2
    localparam logic [3:0] ST_RY  = 4'd1;   // + dy^2
    localparam logic [3:0] ST_RZ  = 4'd2;   // + dz^2
    localparam logic [3:0] ST_SIG = 4'd3;   // sigma^2, then divide by r2
    localparam logic [3:0] ST_Q2  = 4'd4;   // Q*Q
    localparam logic [3:0] ST_Q3  = 4'd5;   // Q2*Q
    localparam logic [3:0] ST_K   = 4'd6;   // epsilon scaling
    localparam logic [3:0] ST_W1  = 4'd7;   // K*Q3
    localparam logic [3:0] ST_W   = 4'd8;   // *|T|
    localparam logic [3:0] ST_X   = 4'd9;   // *|d| per axis, then divide

    localparam logic [63:0] TWO32 = 64'h1_0000_0000;

    logic [3:0]  state_reg;
    logic [3:0]  step_reg;
    logic [1:0]  comp_reg;
    logic [19:0] sigma_reg;
    logic [23:0] eps_reg;

    ljpf_in_t    item_reg;
    logic [30:0] mag_reg [3];
    logic        dneg_reg [3];
    logic [9:0]  q1_reg;
    logic [9:0]  q2i_reg;
    logic [AW:0] e1_reg;
    logic [AW:0] e2_reg;

    logic [63:0]  r2_reg;
    logic [63:0]  q_reg;
    logic [63:0]  qq_reg;
    logic [62:0]  q3_reg;
    logic [63:0]  tmag_reg;
    logic         tpos_reg;
    logic [58:0]  k_reg;
    logic [121:0] w1_reg;
    logic [185:0] w_reg;

    logic [DIV_HI_W-1:0] div_hi_reg;
    logic [DIV_W-1:0]    div_lo_reg;

    logic signed [FORCE_WIDTH-1:0] f_reg [3];
    logic                          flag_reg;
    sum3_t                         sum1_reg;
    sum3_t                         sum2_reg;

    logic      m_valid_reg;
    ljpf_out_t m_item_reg;

    // Per-axis difference, magnitude and far-pair detection.
    logic signed [31:0] p1 [3];
    logic signed [31:0] p2 [3];
    logic signed [32:0] d_c [3];
    logic [32:0]        mag_c [3];
    logic               far_c;

    // Shared unit hookup.
    logic               mac_start;
    logic [MAC_A_W-1:0] mac_a;
    logic [MAC_B_W-1:0] mac_b;
    logic [2:0]         mac_limbs;
    mac_res_t           mac_res;
    logic               div_start;
    div_res_t           div_res;

    // Accumulator memory hookup.
    logic        mem_rd_en;
    logic [AW:0] mem_rd_addr;
    sum3_t       mem_rd_data;
    logic        mem_wr_en;
    logic [AW:0] mem_wr_addr;
    sum3_t       mem_wr_data;
    logic        init_busy;

    // Helper values used by the sequencer.
    logic [63:0]  r2_sum;
    logic [63:0]  q3_a;
    logic         q3_tpos;
    logic [63:0]  q3_tmag;
    logic [63:0]  f_mag;
    logic signed [FORCE_WIDTH-1:0] f_val;
    logic         f_neg;
    sum3_t        acc1;
    sum3_t        acc2;

    function automatic logic [AW-1:0] mod_fix(input logic [9:0] idx, input logic [9:0] qe);
        logic [26:0] r;
        r = {17'b0, idx} - 27'(27'(qe) * 27'(AC_V));
        if (r >= {10'b0, AC_V}) begin
            r = r - {10'b0, AC_V};
        end
        return r[AW-1:0];
    endfunction

    assign p1[0] = item_reg.first_px;
    assign p1[1] = item_reg.first_py;
    assign p1[2] = item_reg.first_pz;
    assign p2[0] = item_reg.second_px;
    assign p2[1] = item_reg.second_py;
    assign p2[2] = item_reg.second_pz;

    always_comb begin
        far_c = 1'b0;
        for (int i = 0; i < 3; i++) begin
            d_c[i]   = {p1[i][31], p1[i]} - {p2[i][31], p2[i]};
            mag_c[i] = d_c[i][32] ? 33'(-d_c[i]) : 33'(d_c[i]);
            if (mag_c[i][32:31] != 2'b00) begin
                far_c = 1'b1;
            end
        end
    end

    // Operands of the shared multiplier for each step.
    always_comb begin
        mac_a     = '0;
        mac_b     = '0;
        mac_limbs = 3'd1;
        case (step_reg)
            ST_RX: begin
                mac_a = MAC_A_W'(mag_reg[0]);
                mac_b = MAC_B_W'(mag_reg[0]);
            end
            ST_RY: begin
                mac_a = MAC_A_W'(mag_reg[1]);
                mac_b = MAC_B_W'(mag_reg[1]);
            end
            ST_RZ: begin
                mac_a = MAC_A_W'(mag_reg[2]);
                mac_b = MAC_B_W'(mag_reg[2]);
            end
            ST_SIG: begin
                mac_a = MAC_A_W'(sigma_reg);
                mac_b = MAC_B_W'(sigma_reg);
            end
            ST_Q2: begin
                mac_a     = MAC_A_W'(q_reg);
                mac_b     = q_reg;
                mac_limbs = 3'd2;
            end
            ST_Q3: begin
                mac_a     = MAC_A_W'(qq_reg);
                mac_b     = q_reg;
                mac_limbs = 3'd2;
            end
            ST_K: begin
                mac_a = MAC_A_W'(eps_reg);
                mac_b = K_SCALE;
            end
            ST_W1: begin
                mac_a     = MAC_A_W'(k_reg);
                mac_b     = MAC_B_W'(q3_reg);
                mac_limbs = 3'd2;
            end
            ST_W: begin
                mac_a     = MAC_A_W'(w1_reg);
                mac_b     = tmag_reg;
                mac_limbs = 3'd4;
            end
            ST_X: begin
                mac_a     = MAC_A_W'(w_reg);
                mac_b     = MAC_B_W'(mag_reg[comp_reg]);
                mac_limbs = 3'd6;
            end
            default: begin
                mac_a = '0;
            end
        endcase
    end

    assign r2_sum  = r2_reg + mac_res.prod[63:0];

    // T = 2*(s/r)^6 - 1 in 32 fraction bits, split into sign and magnitude.
    assign q3_a    = {mac_res.prod[94:32], 1'b0};
    assign q3_tpos = q3_a >= TWO32;
    assign q3_tmag = q3_tpos ? (q3_a - TWO32) : (TWO32 - q3_a);

    // Saturated magnitude and sign of one force component.
    assign f_mag = (div_res.ovf || div_res.quot > {{(64-FORCE_WIDTH){1'b0}}, F_MAX})
                 ? {{(64-FORCE_WIDTH){1'b0}}, F_MAX} : div_res.quot;
    assign f_neg = dneg_reg[comp_reg] ^ ~tpos_reg;
    assign f_val = f_neg ? -f_mag[FORCE_WIDTH-1:0] : f_mag[FORCE_WIDTH-1:0];

    assign acc1.x = sat_add(mem_rd_data.x, f_reg[0]);
    assign acc1.y = sat_add(mem_rd_data.y, f_reg[1]);
    assign acc1.z = sat_add(mem_rd_data.z, f_reg[2]);
    assign acc2.x = sat_add(mem_rd_data.x, -f_reg[0]);
    assign acc2.y = sat_add(mem_rd_data.y, -f_reg[1]);
    assign acc2.z = sat_add(mem_rd_data.z, -f_reg[2]);

    assign mac_start = (state_reg == S_MSTART);
    assign div_start = (state_reg == S_DSTART);

    // Memory port use: read first atom, write it, read second atom, write it unless clearing.
    always_comb begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = e1_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = e1_reg;
        mem_wr_data = '0;
        unique case (state_reg)
            S_RD1: begin
                mem_rd_en = 1'b1;
            end
            S_WR1: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = item_reg.func ? sum3_t'('0) : acc1;
            end
            S_RD2: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = e2_reg;
            end
            S_WR2: begin
                mem_wr_en   = !item_reg.func;
                mem_wr_addr = e2_reg;
                mem_wr_data = acc2;
            end
            default: begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Configuration registers; writes land only while the core is idle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sigma_reg <= SIGMA_RST;
            eps_reg   <= EPSILON_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SIGMA:   sigma_reg <= cfg_data[19:0];
                CFG_EPSILON: eps_reg   <= cfg_data;
                default:     sigma_reg <= sigma_reg;
            endcase
        end
    end

    // Main sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            step_reg    <= ST_RX;
            comp_reg    <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            // The output state handles its own hand-off of the result register.
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        item_reg  <= s_item;
                        state_reg <= S_PREP;
                    end
                end
                S_PREP: begin
                    for (int i = 0; i < 3; i++) begin
                        mag_reg[i]  <= mag_c[i][30:0];
                        dneg_reg[i] <= d_c[i][32];
                        f_reg[i]    <= '0;
                    end
                    flag_reg  <= 1'b0;
                    q1_reg    <= 10'(({21'b0, item_reg.first_index} * {10'b0, RECIP}) >> 20);
                    q2i_reg   <= 10'(({21'b0, item_reg.second_index} * {10'b0, RECIP}) >> 20);
                    state_reg <= S_ADDR;
                    // A far pair has a force below one unit: nothing to compute.
                    if (far_c) begin
                        item_reg.func <= item_reg.func;
                    end
                end
                S_ADDR: begin
                    e1_reg <= {item_reg.bank, mod_fix(item_reg.first_index, q1_reg)};
                    e2_reg <= {item_reg.bank, mod_fix(item_reg.second_index, q2i_reg)};
                    if (item_reg.func || far_c) begin
                        state_reg <= S_RD1;
                    end else begin
                        step_reg  <= ST_RX;
                        state_reg <= S_MSTART;
                    end
                end
                S_MSTART: begin
                    state_reg <= S_MWAIT;
                end
                S_MWAIT: begin
                    if (mac_res.done) begin
                        state_reg <= S_MSTART;
                        case (step_reg)
                            ST_RX: begin
                                r2_reg   <= mac_res.prod[63:0];
                                step_reg <= ST_RY;
                            end
                            ST_RY: begin
                                r2_reg   <= r2_sum;
                                step_reg <= ST_RZ;
                            end
                            ST_RZ: begin
                                r2_reg   <= r2_sum;
                                step_reg <= ST_SIG;
                                if (r2_sum == 64'd0) begin
                                    flag_reg  <= 1'b1;
                                    state_reg <= S_RD1;
                                end else if (eps_reg == 24'd0) begin
                                    state_reg <= S_RD1;
                                end
                            end
                            ST_SIG: begin
                                // Numerator is sigma^2 * 2^32.
                                div_hi_reg <= DIV_HI_W'(mac_res.prod[39:32]);
                                div_lo_reg <= {mac_res.prod[31:0], 32'b0};
                                state_reg  <= S_DSTART;
                            end
                            ST_Q2: begin
                                qq_reg   <= mac_res.prod[95:32];
                                step_reg <= ST_Q3;
                                if (mac_res.prod[MAC_P_W-1:96] != '0) begin
                                    state_reg <= S_HUGE;
                                end
                            end
                            ST_Q3: begin
                                q3_reg   <= mac_res.prod[94:32];
                                tmag_reg <= q3_tmag;
                                tpos_reg <= q3_tpos;
                                step_reg <= ST_K;
                                if (mac_res.prod[MAC_P_W-1:95] != '0) begin
                                    state_reg <= S_HUGE;
                                end else if (mac_res.prod[94:32] == 63'd0 || q3_tmag == 64'd0) begin
                                    state_reg <= S_RD1;
                                end
                            end
                            ST_K: begin
                                k_reg    <= mac_res.prod[58:0];
                                step_reg <= ST_W1;
                            end
                            ST_W1: begin
                                w1_reg   <= mac_res.prod[121:0];
                                step_reg <= ST_W;
                            end
                            ST_W: begin
                                w_reg     <= mac_res.prod[185:0];
                                comp_reg  <= 2'd0;
                                step_reg  <= ST_X;
                                state_reg <= S_COMP;
                            end
                            ST_X: begin
                                // Divide (X / 2^64) by r2: high part and next 64 bits.
                                div_hi_reg <= mac_res.prod[217:128];
                                div_lo_reg <= mac_res.prod[127:64];
                                state_reg  <= S_DSTART;
                            end
                            default: begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_DSTART: begin
                    state_reg <= S_DWAIT;
                end
                S_DWAIT: begin
                    if (div_res.done) begin
                        if (step_reg == ST_SIG) begin
                            q_reg     <= div_res.quot;
                            step_reg  <= ST_Q2;
                            state_reg <= div_res.ovf ? S_HUGE : S_MSTART;
                        end else begin
                            f_reg[comp_reg] <= f_val;
                            if (comp_reg == 2'd2) begin
                                state_reg <= S_RD1;
                            end else begin
                                comp_reg  <= comp_reg + 2'd1;
                                state_reg <= S_COMP;
                            end
                        end
                    end
                end
                S_COMP: begin
                    if (mag_reg[comp_reg] != 31'd0) begin
                        state_reg <= S_MSTART;
                    end else if (comp_reg == 2'd2) begin
                        state_reg <= S_RD1;
                    end else begin
                        comp_reg <= comp_reg + 2'd1;
                    end
                end
                S_HUGE: begin
                    // Repulsion surely saturates: full force along each nonzero axis.
                    for (int i = 0; i < 3; i++) begin
                        if (mag_reg[i] == 31'd0) begin
                            f_reg[i] <= '0;
                        end else begin
                            f_reg[i] <= dneg_reg[i] ? -F_MAX : F_MAX;
                        end
                    end
                    state_reg <= S_RD1;
                end
                S_RD1: begin
                    state_reg <= S_WR1;
                end
                S_WR1: begin
                    sum1_reg  <= item_reg.func ? sum3_t'('0) : acc1;
                    state_reg <= S_RD2;
                end
                S_RD2: begin
                    state_reg <= S_WR2;
                end
                S_WR2: begin
                    if (item_reg.func) begin
                        sum2_reg <= mem_rd_data;
                    end else begin
                        sum2_reg <= acc2;
                        // Same atom on both sides: both report the final sum.
                        if (e1_reg == e2_reg) begin
                            sum1_reg <= acc2;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_item_reg.pair_fx       <= f_reg[0];
                        m_item_reg.pair_fy       <= f_reg[1];
                        m_item_reg.pair_fz       <= f_reg[2];
                        m_item_reg.sum_first_x   <= sum1_reg.x;
                        m_item_reg.sum_first_y   <= sum1_reg.y;
                        m_item_reg.sum_first_z   <= sum1_reg.z;
                        m_item_reg.sum_second_x  <= sum2_reg.x;
                        m_item_reg.sum_second_y  <= sum2_reg.y;
                        m_item_reg.sum_second_z  <= sum2_reg.z;
                        m_item_reg.zero_distance <= flag_reg;
                        m_valid_reg              <= 1'b1;
                        state_reg                <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    ljpf_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mac_start),
        .op_a    (mac_a),
        .op_b    (mac_b),
        .a_limbs (mac_limbs),
        .res     (mac_res)
    );

    ljpf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .hi      (div_hi_reg),
        .lo      (div_lo_reg),
        .divisor (r2_reg),
        .res     (div_res)
    );

    ljpf_sum_mem #(
        .ATOM_COUNT (ATOM_COUNT)
    ) u_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (mem_rd_en),
        .rd_addr   (mem_rd_addr),
        .rd_data   (mem_rd_data),
        .wr_en     (mem_wr_en),
        .wr_addr   (mem_wr_addr),
        .wr_data   (mem_wr_data),
        .init_busy (init_busy)
    );

    // Items are taken only in idle and never during the zeroing sweep.
    assign s_ready   = (state_reg == S_IDLE) && !init_busy;
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

    a_no_take_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        init_busy |-> !s_ready)
        else $error("item taken during accumulator sweep");
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");
    a_units_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(mac_res.done && div_res.done))
        else $error("multiplier and divider finished together");
    a_write_in_update: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == S_WR1 || state_reg == S_WR2))
        else $error("accumulator written outside an update step");

endmodule

// File: rtl/ljpf_mac.sv
// ----------------------------------------------------------------------------
// ljpf_mac
// Shared multiplier: one 32x32 limb product per cycle, accumulated into a
// wide product register.
// ----------------------------------------------------------------------------
module ljpf_mac import ljpf_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [MAC_A_W-1:0] op_a,
    input  logic [MAC_B_W-1:0] op_b,
    input  logic [2:0]         a_limbs,
    output mac_res_t           res
);

    logic [MAC_A_W-1:0] a_reg;
    logic [MAC_B_W-1:0] b_reg;
    logic [2:0]         last_reg;
    logic [2:0]         i_reg;
    logic               j_reg;
    logic               issue_reg;
    logic               pend_reg;
    logic               done_reg;
    logic [63:0]        p_reg;
    logic [2:0]         sh_reg;
    logic [MAC_P_W-1:0] acc_reg;
    logic [MAC_P_W-1:0] addend;

    assign addend = {{(MAC_P_W-64){1'b0}}, p_reg} << {sh_reg, 5'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_reg <= 1'b0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            pend_reg <= issue_reg;
            done_reg <= pend_reg && !issue_reg;
            if (start) begin
                a_reg     <= op_a;
                b_reg     <= op_b;
                last_reg  <= a_limbs - 3'd1;
                i_reg     <= 3'd0;
                j_reg     <= 1'b0;
                issue_reg <= 1'b1;
                acc_reg   <= '0;
            end else begin
                if (issue_reg) begin
                    p_reg  <= a_reg[i_reg*LIMB_W +: LIMB_W] * b_reg[j_reg*LIMB_W +: LIMB_W];
                    sh_reg <= i_reg + {2'b0, j_reg};
                    j_reg  <= ~j_reg;
                    if (j_reg) begin
                        i_reg <= i_reg + 3'd1;
                        if (i_reg == last_reg) begin
                            issue_reg <= 1'b0;
                        end
                    end
                end
                if (pend_reg) begin
                    acc_reg <= acc_reg + addend;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.prod = acc_reg;

endmodule

// File: rtl/ljpf_div.sv
// ----------------------------------------------------------------------------
// ljpf_div
// Restoring divider, one quotient bit per cycle, with an up-front overflow
// check for quotients of 2^64 or more.
// ----------------------------------------------------------------------------
module ljpf_div import ljpf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_HI_W-1:0] hi,
    input  logic [DIV_W-1:0]    lo,
    input  logic [DIV_W-1:0]    divisor,
    output div_res_t            res
);

    logic             busy_reg;
    logic             done_reg;
    logic             ovf_reg;
    logic [6:0]       cnt_reg;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] lo_reg;
    logic [DIV_W-1:0] dvs_reg;
    logic [DIV_W-1:0] quot_reg;
    logic [DIV_W:0]   rem_sh;
    logic             ge;

    assign rem_sh = {rem_reg, lo_reg[DIV_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvs_reg <= divisor;
                lo_reg  <= lo;
                rem_reg <= hi[DIV_W-1:0];
                cnt_reg <= 7'd64;
                if (hi >= {{(DIV_HI_W-DIV_W){1'b0}}, divisor}) begin
                    ovf_reg  <= 1'b1;
                    done_reg <= 1'b1;
                end else begin
                    ovf_reg  <= 1'b0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                rem_reg  <= ge ? DIV_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DIV_W-1:0];
                quot_reg <= {quot_reg[DIV_W-2:0], ge};
                lo_reg   <= {lo_reg[DIV_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quot = quot_reg;

    // An overflowing divide finishes without stepping.
    a_ovf_nobusy: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && ovf_reg) |-> !busy_reg)
        else $error("divider busy after overflow");
    a_done_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == 7'd1 && !start) |=> (done_reg && !busy_reg))
        else $error("divider did not finish on its last step");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !$past(start)) |-> $past(busy_reg))
        else $error("divider done without work");

endmodule

// File: rtl/ljpf_sum_mem.sv
// ----------------------------------------------------------------------------
// ljpf_sum_mem
// Force accumulator storage for both banks, with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module ljpf_sum_mem import ljpf_pkg::*; #(
    parameter int ATOM_COUNT = ATOM_COUNT_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           rd_en,
    input  logic [$clog2(ATOM_COUNT):0]    rd_addr,
    output sum3_t                          rd_data,
    input  logic                           wr_en,
    input  logic [$clog2(ATOM_COUNT):0]    wr_addr,
    input  sum3_t                          wr_data,
    output logic                           init_busy
);

    localparam int AW    = $clog2(ATOM_COUNT);
    localparam int DEPTH = 2 ** (AW + 1);

    sum3_t         mem [DEPTH];
    sum3_t         rd_data_reg;
    logic          init_busy_reg;
    logic [AW:0]   clr_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_busy_reg <= 1'b1;
            clr_addr_reg  <= '0;
        end else if (init_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {(AW+1){1'b1}}) begin
                init_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (init_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data   = rd_data_reg;
    assign init_busy = init_busy_reg;

endmodule

// File: tb/lennard_jones_pair_force_accumulate_core_checker.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_accumulate_core_checker
// Watches the item, result and register channels of the pair force core,
// predicts every result from its own copy of the sums and registers, and
// compares the results field by field in order.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_accumulate_core_checker import ljpf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  ljpf_in_t              s_item,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  ljpf_out_t             m_item,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending,
    output int                    checked
);

    localparam int SLOTS = 2 * ATOM_COUNT_DEF;

    logic signed [FORCE_WIDTH-1:0] acc_x [SLOTS];
    logic signed [FORCE_WIDTH-1:0] acc_y [SLOTS];
    logic signed [FORCE_WIDTH-1:0] acc_z [SLOTS];
    logic [19:0] sigma_q;
    logic [23:0] eps_q;
    ljpf_out_t   expected_results [$];

    initial begin
        errors  = 0;
        checked = 0;
    end

    assign pending = expected_results.size();

    function automatic logic signed [FORCE_WIDTH-1:0] clamp_add(
        input logic signed [FORCE_WIDTH-1:0] a,
        input logic signed [FORCE_WIDTH-1:0] b
    );
        logic signed [FORCE_WIDTH:0] s;
        s = $signed({a[FORCE_WIDTH-1], a}) + $signed({b[FORCE_WIDTH-1], b});
        if (s > $signed({F_MAX[FORCE_WIDTH-1], F_MAX})) return F_MAX;
        if (s < $signed({F_MIN[FORCE_WIDTH-1], F_MIN})) return F_MIN;
        return s[FORCE_WIDTH-1:0];
    endfunction

    // Fixed-point 12-6 force on the first atom for separation d.
    function automatic sum3_t lj_force(
        input  logic signed [32:0] dx,
        input  logic signed [32:0] dy,
        input  logic signed [32:0] dz,
        output logic               coincide
    );
        logic signed [32:0]            d [3];
        logic signed [32:0]            neg;
        logic [31:0]                   mag [3];
        logic signed [FORCE_WIDTH-1:0] f [3];
        logic [63:0]  r2, q, q2, q3, a, tmag, k;
        logic [255:0] w;
        logic         far, huge, tpos, flip;
        logic [FORCE_WIDTH-1:0] m;
        sum3_t        res;
        d[0] = dx; d[1] = dy; d[2] = dz;
        coincide = 1'b0;
        far = 1'b0;
        huge = 1'b0;
        r2 = '0;
        q2 = '0;
        q3 = '0;
        k = 64'(eps_q) * K_SCALE;
        for (int i = 0; i < 3; i++) begin
            f[i] = '0;
            neg = -d[i];
            mag[i] = d[i] < 0 ? neg[31:0] : d[i][31:0];
            if (mag[i][31]) far = 1'b1;
            r2 = r2 + {32'd0, mag[i]} * {32'd0, mag[i]};
        end
        if (!far && r2 == 0) begin
            coincide = 1'b1;
        end else if (!far && k != 0) begin
            w = (256'(sigma_q) * 256'(sigma_q) << 32) / 256'(r2);
            huge = w[255:64] != 0;
            q = w[63:0];
            if (!huge) begin
                w = (256'(q) * 256'(q)) >> 32;
                huge = w[255:64] != 0;
                q2 = w[63:0];
            end
            if (!huge) begin
                w = (256'(q2) * 256'(q)) >> 32;
                q3 = w[63:0];
                huge = w[255:64] != 0 || q3[63];
            end
            if (huge) begin
                // Atoms so close that every axis with any offset pins at the rail.
                for (int i = 0; i < 3; i++)
                    f[i] = d[i] > 0 ? F_MAX : (d[i] < 0 ? -F_MAX : '0);
            end else begin
                a = q3 << 1;
                tpos = a >= 64'h1_0000_0000;
                tmag = tpos ? a - 64'h1_0000_0000 : 64'h1_0000_0000 - a;
                if (q3 != 0 && tmag != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        if (mag[i] != 0) begin
                            w = 256'(k) * 256'(mag[i]) * 256'(q3) * 256'(tmag);
                            w = (w / 256'(r2)) >> 64;
                            m = (w[255:FORCE_WIDTH-1] != 0) ? F_MAX : w[FORCE_WIDTH-1:0];
                            flip = (d[i] < 0) != !tpos;
                            f[i] = flip ? -$signed(m) : $signed(m);
                        end
                    end
                end
            end
        end
        res.x = f[0];
        res.y = f[1];
        res.z = f[2];
        return res;
    endfunction

    function automatic ljpf_out_t predict_result(input ljpf_in_t it);
        ljpf_out_t r;
        sum3_t     f;
        logic      zd;
        int        e1, e2;
        e1 = it.bank * ATOM_COUNT_DEF + it.first_index;
        e2 = it.bank * ATOM_COUNT_DEF + it.second_index;
        f = '0;
        zd = 1'b0;
        if (it.func == 1'b0) begin
            f = lj_force(33'(it.first_px) - 33'(it.second_px),
                         33'(it.first_py) - 33'(it.second_py),
                         33'(it.first_pz) - 33'(it.second_pz), zd);
            acc_x[e1] = clamp_add(acc_x[e1], f.x);
            acc_y[e1] = clamp_add(acc_y[e1], f.y);
            acc_z[e1] = clamp_add(acc_z[e1], f.z);
            acc_x[e2] = clamp_add(acc_x[e2], -f.x);
            acc_y[e2] = clamp_add(acc_y[e2], -f.y);
            acc_z[e2] = clamp_add(acc_z[e2], -f.z);
        end else begin
            acc_x[e1] = '0;
            acc_y[e1] = '0;
            acc_z[e1] = '0;
        end
        r.pair_fx = f.x;
        r.pair_fy = f.y;
        r.pair_fz = f.z;
        r.sum_first_x = acc_x[e1];
        r.sum_first_y = acc_y[e1];
        r.sum_first_z = acc_z[e1];
        r.sum_second_x = acc_x[e2];
        r.sum_second_y = acc_y[e2];
        r.sum_second_z = acc_z[e2];
        r.zero_distance = zd;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [FORCE_WIDTH-1:0] got,
                                   input logic [FORCE_WIDTH-1:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", checked, what, got, want);
        errors++;
    endtask

    task automatic compare_field(input string what, input logic [FORCE_WIDTH-1:0] got,
                                 input logic [FORCE_WIDTH-1:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge aclk) begin
        ljpf_out_t want;
        if (!aresetn) begin
            for (int i = 0; i < SLOTS; i++) begin
                acc_x[i] = '0;
                acc_y[i] = '0;
                acc_z[i] = '0;
            end
            sigma_q = SIGMA_RST;
            eps_q = EPSILON_RST;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_SIGMA) sigma_q = cfg_data[19:0];
                else if (cfg_index == CFG_EPSILON) eps_q = cfg_data[23:0];
            end
            if (s_valid && s_ready) expected_results.push_back(predict_result(s_item));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", '0, '0);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("pair_fx", m_item.pair_fx, want.pair_fx);
                    compare_field("pair_fy", m_item.pair_fy, want.pair_fy);
                    compare_field("pair_fz", m_item.pair_fz, want.pair_fz);
                    compare_field("sum_first_x", m_item.sum_first_x, want.sum_first_x);
                    compare_field("sum_first_y", m_item.sum_first_y, want.sum_first_y);
                    compare_field("sum_first_z", m_item.sum_first_z, want.sum_first_z);
                    compare_field("sum_second_x", m_item.sum_second_x, want.sum_second_x);
                    compare_field("sum_second_y", m_item.sum_second_y, want.sum_second_y);
                    compare_field("sum_second_z", m_item.sum_second_z, want.sum_second_z);
                    compare_field("zero_distance", FORCE_WIDTH'(m_item.zero_distance),
                                  FORCE_WIDTH'(want.zero_distance));
                end
                checked++;
            end
        end
    end

endmodule

// File: tb/lennard_jones_pair_force_accumulate_core_tb.sv
// ----------------------------------------------------------------------------
// lennard_jones_pair_force_accumulate_core_tb
// Drives the pair force core with directed and random items under several
// register settings, with bursty input and a stalling result side; the
// checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_accumulate_core_tb;
    import ljpf_pkg::*;

    // The limit leaves wide margin beyond the pair force work for the clearing
    // sweep, receiver stalls and sender gaps.
    localparam int CYCLE_LIMIT = 6000000;
    localparam int ITEMS_PER_SETTING = 400;
    localparam int IN_W = $bits(ljpf_in_t);

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    ljpf_in_t              s_item = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    ljpf_out_t             m_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_SIGMA;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int errors, pending, checked;
    int cycles = 0;
    int sent = 0;
    int stall_mode = 0;

    lennard_jones_pair_force_accumulate_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    lennard_jones_pair_force_accumulate_core_checker force_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending), .checked(checked)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The watchdog ends a hung run.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // The result side switches between always ready and three levels of random
    // stalling.
    always @(posedge aclk) begin
        if (cycles % 500 == 0) stall_mode <= $urandom_range(0, 3);
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (stall_mode == 0) || ($urandom_range(0, 3) >= stall_mode);
    end

    // Builds an item whose first atom sits at the second atom plus d; the second atom's position derives from base.
    function automatic ljpf_in_t pair_item(input logic fn, input logic [9:0] i1,
                                           input logic [9:0] i2, input logic bk,
                                           input int dx, input int dy, input int dz,
                                           input logic [31:0] base);
        ljpf_in_t it;
        it.func = fn;
        it.first_index = i1;
        it.second_index = i2;
        it.bank = bk;
        it.second_px = base;
        it.second_py = base ^ 32'h5a5a;
        it.second_pz = -base;
        it.first_px = it.second_px + dx;
        it.first_py = it.second_py + dy;
        it.first_pz = it.second_pz + dz;
        return it;
    endfunction

    // One random axis offset inside +-lim.
    function automatic int rand_offset(input int unsigned lim);
        int v;
        v = int'($urandom_range(0, lim));
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    function automatic ljpf_in_t random_item();
        ljpf_in_t it;
        int unsigned lim;
        int sel;
        logic [9:0] i1, i2;
        sel = $urandom_range(0, 99);
        // A small pool of atoms makes sums build up and saturate.
        i1 = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(0, 7));
        i2 = $urandom_range(0, 3) == 0 ? 10'($urandom) : 10'($urandom_range(1016, 1023));
        if ($urandom_range(0, 15) == 0) i2 = i1;
        case ($urandom_range(0, 4))
            0: lim = 2000;
            1: lim = 60000;
            2: lim = 500000;
            3: lim = 1500000;
            default: lim = 32'h7fff_ffff;
        endcase
        if (sel < 70) begin
            it = pair_item(1'b0, i1, i2, 1'($urandom), rand_offset(lim), rand_offset(lim),
                           rand_offset(lim), $urandom);
        end else if (sel < 80) begin
            it = pair_item(1'b1, i1, i2, 1'($urandom), 0, 0, 0, $urandom);
        end else if (sel < 84) begin
            it = pair_item(1'b0, i1, i2, 1'($urandom), 0, 0, 0, $urandom);
        end else begin
            it = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom});
        end
        return it;
    endfunction

    // Holds valid until the core takes the item; valid is left high so the
    // next item of a burst follows without a gap.
    task automatic push_item(input ljpf_in_t it);
        s_valid <= 1'b1;
        s_item <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_phase(input int count);
        int burst;
        for (int n = 0; n < count; n += burst) begin
            burst = $urandom_range(1, 20);
            for (int b = 0; b < burst; b++) push_item(random_item());
            if ($urandom_range(0, 2) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end
        end
    endtask

    initial begin
        ljpf_in_t it;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset settings.
        push_item(pair_item(1'b1, 10'd5, 10'd6, 1'b0, 0, 0, 0, 32'd0));
        push_item(pair_item(1'b0, 10'd1, 10'd2, 1'b0, 0, 0, 0, 32'd12345));
        it = pair_item(1'b0, 10'd3, 10'd4, 1'b0, 0, 0, 0, 32'd0);
        it.first_px = 32'h7fff_ffff;
        it.second_px = 32'h8000_0000;
        push_item(it);
        it.first_px = 32'h8000_0000;
        it.second_px = 32'h7fff_ffff;
        it.first_pz = 32'hffff_ffff;
        it.second_pz = 32'hffff_ffff;
        push_item(it);
        // Nearly touching atoms pin the force; repeating it saturates the sums.
        push_item(pair_item(1'b0, 10'd10, 10'd11, 1'b0, 1, 0, -1, 32'd0));
        push_item(pair_item(1'b0, 10'd10, 10'd11, 1'b0, 1, 0, -1, 32'd0));
        push_item(pair_item(1'b0, 10'd10, 10'd11, 1'b0, 1, 0, -1, 32'd0));
        push_item(pair_item(1'b0, 10'd20, 10'd21, 1'b0, 400000, 0, 0, 32'd77));
        push_item(pair_item(1'b0, 10'd20, 10'd21, 1'b0, 300000, -200000, 100000, 32'd77));
        push_item(pair_item(1'b0, 10'd7, 10'd7, 1'b0, 250000, 0, 0, 32'd0));
        push_item(pair_item(1'b0, 10'd1023, 10'd0, 1'b1, -330000, -10, 5, 32'hdead_beef));
        push_item(pair_item(1'b0, 10'd0, 10'd1023, 1'b1, 1500000, 1500000, 1500000, 32'd3));
        push_item(pair_item(1'b1, 10'd10, 10'd11, 1'b0, 0, 0, 0, 32'd0));
        push_item(pair_item(1'b1, 10'd1023, 10'd0, 1'b1, 0, 0, 0, 32'd0));
        push_item(pair_item(1'b0, 10'd30, 10'd31, 1'b0, 356000, 0, 0, 32'd0));
        drain();

        random_phase(ITEMS_PER_SETTING);
        drain();

        write_reg(CFG_SIGMA, 24'd1048575);
        write_reg(CFG_EPSILON, 24'd16777215);
        push_item(pair_item(1'b0, 10'd40, 10'd41, 1'b0, 1000000, 0, 0, 32'd0));
        random_phase(ITEMS_PER_SETTING);
        drain();

        write_reg(CFG_SIGMA, 24'd1);
        write_reg(CFG_EPSILON, 24'd1);
        push_item(pair_item(1'b0, 10'd40, 10'd41, 1'b0, 1, 1, 1, 32'd0));
        random_phase(ITEMS_PER_SETTING);
        drain();

        write_reg(CFG_SIGMA, 24'($urandom_range(1, 1048575)));
        write_reg(CFG_EPSILON, 24'($urandom_range(1, 16777215)));
        random_phase(ITEMS_PER_SETTING);
        drain();
        repeat (50) @(posedge aclk);

        $display("Sent %0d items over four register settings; checked %0d results.",
                 sent, checked);
        $display("Covered clears, coinciding, distant and pinned pairs and sum clamping.");
        if (errors == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
